// ----- rtl/hsi_pkg.sv -----
// Shared constants of the Hermite spline interpolator.
package hsi_pkg;

    // Default fixed-point layout of values, times and the weight
    localparam int HSI_FRAC_BITS   = 16;
    localparam int HSI_VALUE_WIDTH = 32;

endpackage

// ----- rtl/hsi_mul.sv -----
// Two-stage unsigned multiplier built from four registered partial products.
module hsi_mul
    import hsi_pkg::*;
#(
    parameter int AW = HSI_VALUE_WIDTH,
    parameter int BW = HSI_VALUE_WIDTH
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg, ll_next;
    logic [AL+BH-1:0] lh_reg, lh_next;
    logic [AH+BL-1:0] hl_reg, hl_next;
    logic [AH+BH-1:0] hh_reg, hh_next;
    logic [PW-1:0]    p_reg, p_next;

    always_comb
    begin
        ll_next = (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
        lh_next = (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
        hl_next = (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
        hh_next = (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
        // align and sum the partial products
        p_next  = PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
                + (PW'(hh_reg) << (AL + BL));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/hsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module hsi_div
    import hsi_pkg::*;
#(
    parameter int NW = 3 * HSI_FRAC_BITS + 1 + 2 * HSI_VALUE_WIDTH,
    parameter int DW = HSI_VALUE_WIDTH
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [DW-1:0] den_out
);

    // rq holds the numerator bits still to be consumed, quotient bits fill in below
    logic [NW-1:0] rq_reg  [NW];
    logic [NW-1:0] rq_next [NW];
    logic [DW-1:0] rm_reg  [NW];
    logic [DW-1:0] rm_next [NW];
    logic [DW-1:0] dn_reg  [NW];
    logic [DW-1:0] dn_next [NW];

    always_comb
    begin
        logic [NW-1:0] rq_in;
        logic [DW-1:0] rm_in;
        logic [DW-1:0] dn_in;
        logic [DW:0]   trial;
        logic          ge;
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                rq_in = num;
                rm_in = '0;
                dn_in = den;
            end
            else
            begin
                rq_in = rq_reg[k-1];
                rm_in = rm_reg[k-1];
                dn_in = dn_reg[k-1];
            end
            trial      = {rm_in, rq_in[NW-1]};
            ge         = trial >= {1'b0, dn_in};
            rm_next[k] = ge ? DW'(trial - {1'b0, dn_in}) : trial[DW-1:0];
            rq_next[k] = {rq_in[NW-2:0], ge};
            dn_next[k] = dn_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rq_reg[k] <= rq_next[k];
                rm_reg[k] <= rm_next[k];
                dn_reg[k] <= dn_next[k];
            end
        end
    end

    assign quo     = rq_reg[NW-1];
    assign rem     = rm_reg[NW-1];
    assign den_out = dn_reg[NW-1];

endmodule

// ----- rtl/hermite_spline_interpolate.sv -----
// Non-uniform cubic Hermite spline interpolator for one axis, fully pipelined.
// Tangent width NW = 3*FRAC_BITS + 1 + 2*VALUE_WIDTH (113 at defaults).
// Throughput: one request per cycle while the master side is not stalling; the two
// bit-serial tangent dividers of NW stages set the depth.
// A stall on the master side holds the whole pipeline, nothing is dropped.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep junk.
module hermite_spline_interpolate
    import hsi_pkg::*;
#(
    parameter int FRAC_BITS   = HSI_FRAC_BITS,
    parameter int VALUE_WIDTH = HSI_VALUE_WIDTH,
    localparam int IN_TW  = ((8 * VALUE_WIDTH + FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_TW = ((VALUE_WIDTH + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // pt_before, pt_start, pt_end, pt_after, time_before, time_start,
    // time_end, time_after (VALUE_WIDTH each), weight (FRAC_BITS+1), zero pad
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // value (VALUE_WIDTH), zero pad
    output logic [OUT_TW-1:0] m_tdata,
    // saturated
    output logic              m_tuser
);

    localparam int W   = VALUE_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int HW  = 3 * F + 1;        // basis polynomials, scaled by 2^(3F)
    localparam int NW  = HW + 2 * W;       // tangent numerators and quotients
    localparam int IA  = HW + W + 3;       // endpoint and half-slope sum
    localparam int TW  = NW + 3;           // full integer blend
    localparam int K   = 3 * F + 1;        // blend is scaled by 2^K
    localparam int MW  = TW + 1 - K;       // rounded magnitude
    localparam int LAT = 13 + NW;
    localparam int DIV_OUT = 6 + NW;       // valid index of divider output

    localparam logic [F:0]    ONE_W  = {1'b1, {F{1'b0}}};
    localparam logic [W-1:0]  MAX_V  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MIN_V  = {1'b1, {(W-1){1'b0}}};
    localparam logic [MW-1:0] MINMAG = MW'(1) << (W - 1);
    localparam logic [MW-1:0] MAXMAG = MINMAG - MW'(1);
    localparam logic [TW:0]   HALF   = (TW+1)'(1) << (K - 1);

    typedef struct packed {
        logic [W-1:0] ym1, ym2, dm10, dm21, dm32, xm10, xm21, xm32;
        logic         ys1, ys2, ds10, ds21, ds32, xs10, xs21, xs32;
        logic         e0, e1;
        logic [F:0]   t;
    } s1_t;

    typedef struct packed {
        logic [W-1:0]     ym1, ym2, dm21, xm10, xm32;
        logic             ys1, ys2, ds21, sg0, sg1, e0, e1;
        logic [F:0]       t, u;
        logic [2*F+1:0]   t2, u2;
        logic [2*W-1:0]   p0m, p1m;
    } s2_t;

    typedef struct packed {
        logic [W-1:0]     ym1, ym2, dm21, xm10, xm32;
        logic             ys1, ys2, ds21, sg0, sg1, e0, e1;
        logic [2*F+1:0]   t2;
        logic [HW-1:0]    t3, h10, h11m;
        logic [2*W-1:0]   p0m, p1m;
    } s3_t;

    typedef struct packed {
        logic         ys1, ys2, cs, sg0, sg1, e0, e1;
        logic [W-1:0] xm10, xm32;
    } side_t;

    typedef struct packed {
        side_t          sd;
        logic [W-1:0]   ym1, ym2, dm21;
        logic [HW-1:0]  h00, h01, h10, h11m, hcm;
        logic [2*W-1:0] p0m, p1m;
    } s4_t;

    typedef struct packed {
        logic [IA-1:0] isum;
        logic          sg0, sg1;
    } sb_t;

    typedef struct packed {
        logic [IA-1:0] isum;
        logic [TW-1:0] i0, i1;
        logic [W-1:0]  rr0, rr1, a0, a1;
    } d1_t;

    typedef struct packed {
        logic [TW-1:0]  isum2;
        logic [2*W-1:0] f0, f1, aa;
    } d2_t;

    typedef struct packed {
        logic [TW-1:0] isum2;
        logic          cy, zr;
    } d3_t;

    typedef struct packed {
        logic [TW-1:0] ip;
        logic          zr;
    } d4_t;

    typedef struct packed {
        logic [MW-1:0] mag;
        logic          neg;
    } d5_t;

    function automatic logic [W:0] sx(input logic [W-1:0] v);
        return {v[W-1], v};
    endfunction

    function automatic logic [W-1:0] mag_of(input logic [W:0] v);
        logic [W:0] n;
        n = ~v + 1'b1;
        return v[W] ? n[W-1:0] : v[W-1:0];
    endfunction

    // global advance: the whole pipe moves unless the output request is stuck
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: differences, magnitudes, weight clamp
    logic [W-1:0] pt_before, pt_start, pt_end, pt_after;
    logic [W-1:0] time_before, time_start, time_end, time_after;
    logic [F:0]   weight;

    assign pt_before   = s_tdata[0*W +: W];
    assign pt_start    = s_tdata[1*W +: W];
    assign pt_end      = s_tdata[2*W +: W];
    assign pt_after    = s_tdata[3*W +: W];
    assign time_before = s_tdata[4*W +: W];
    assign time_start  = s_tdata[5*W +: W];
    assign time_end    = s_tdata[6*W +: W];
    assign time_after  = s_tdata[7*W +: W];
    assign weight      = s_tdata[8*W +: F+1];

    s1_t s1_reg, s1_next;

    always_comb
    begin
        logic [W:0] d10, d21, d32, x10, x21, x32;
        d10 = sx(pt_start)   - sx(pt_before);
        d21 = sx(pt_end)     - sx(pt_start);
        d32 = sx(pt_after)   - sx(pt_end);
        x10 = sx(time_start) - sx(time_before);
        x21 = sx(time_end)   - sx(time_start);
        x32 = sx(time_after) - sx(time_end);
        s1_next.ym1  = mag_of(sx(pt_start));
        s1_next.ym2  = mag_of(sx(pt_end));
        s1_next.ys1  = pt_start[W-1];
        s1_next.ys2  = pt_end[W-1];
        s1_next.dm10 = mag_of(d10);
        s1_next.dm21 = mag_of(d21);
        s1_next.dm32 = mag_of(d32);
        s1_next.xm10 = mag_of(x10);
        s1_next.xm21 = mag_of(x21);
        s1_next.xm32 = mag_of(x32);
        s1_next.ds10 = d10[W];
        s1_next.ds21 = d21[W];
        s1_next.ds32 = d32[W];
        s1_next.xs10 = x10[W];
        s1_next.xs21 = x21[W];
        s1_next.xs32 = x32[W];
        // a tangent drops out when either interval it uses is empty
        s1_next.e0   = (x10 != '0) && (x21 != '0);
        s1_next.e1   = (x32 != '0) && (x21 != '0);
        s1_next.t    = (weight > ONE_W) ? ONE_W : weight;
    end

    // ---------------- stage 2: squares of t and 1-t, slope cross products
    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.ym1  = s1_reg.ym1;
        s2_next.ym2  = s1_reg.ym2;
        s2_next.dm21 = s1_reg.dm21;
        s2_next.xm10 = s1_reg.xm10;
        s2_next.xm32 = s1_reg.xm32;
        s2_next.ys1  = s1_reg.ys1;
        s2_next.ys2  = s1_reg.ys2;
        s2_next.ds21 = s1_reg.ds21;
        // sign of h10*d10*dx21/dx10 and of h11*d32*dx21/dx32 (h11 is never positive)
        s2_next.sg0  = s1_reg.ds10 ^ s1_reg.xs21 ^ s1_reg.xs10;
        s2_next.sg1  = 1'b1 ^ s1_reg.ds32 ^ s1_reg.xs21 ^ s1_reg.xs32;
        s2_next.e0   = s1_reg.e0;
        s2_next.e1   = s1_reg.e1;
        s2_next.t    = s1_reg.t;
        s2_next.u    = ONE_W - s1_reg.t;
        s2_next.t2   = (2*F+2)'(s1_reg.t) * (2*F+2)'(s1_reg.t);
        s2_next.u2   = (2*F+2)'(ONE_W - s1_reg.t) * (2*F+2)'(ONE_W - s1_reg.t);
        s2_next.p0m  = (2*W)'(s1_reg.dm10) * (2*W)'(s1_reg.xm21);
        s2_next.p1m  = (2*W)'(s1_reg.dm32) * (2*W)'(s1_reg.xm21);
    end

    // ---------------- stage 3: cubic terms t^3, t(1-t)^2, t^2(1-t)
    s3_t s3_reg, s3_next;

    always_comb
    begin
        logic [3*F+2:0] t3w, h10w, h11w;
        t3w  = (3*F+3)'(s2_reg.t2) * (3*F+3)'(s2_reg.t);
        h10w = (3*F+3)'(s2_reg.u2) * (3*F+3)'(s2_reg.t);
        h11w = (3*F+3)'(s2_reg.t2) * (3*F+3)'(s2_reg.u);
        s3_next.ym1  = s2_reg.ym1;
        s3_next.ym2  = s2_reg.ym2;
        s3_next.dm21 = s2_reg.dm21;
        s3_next.xm10 = s2_reg.xm10;
        s3_next.xm32 = s2_reg.xm32;
        s3_next.ys1  = s2_reg.ys1;
        s3_next.ys2  = s2_reg.ys2;
        s3_next.ds21 = s2_reg.ds21;
        s3_next.sg0  = s2_reg.sg0;
        s3_next.sg1  = s2_reg.sg1;
        s3_next.e0   = s2_reg.e0;
        s3_next.e1   = s2_reg.e1;
        s3_next.t2   = s2_reg.t2;
        s3_next.t3   = t3w[HW-1:0];
        s3_next.h10  = h10w[HW-1:0];
        s3_next.h11m = h11w[HW-1:0];
        s3_next.p0m  = s2_reg.p0m;
        s3_next.p1m  = s2_reg.p1m;
    end

    // ---------------- stage 4: endpoint basis and the combined half-slope weight
    s4_t s4_reg, s4_next;

    always_comb
    begin
        logic [HW+1:0] t2s, t3x, h00w, h01w;
        logic [HW-1:0] he0, he1;
        t2s  = (HW+2)'(s3_reg.t2) << F;
        t3x  = (HW+2)'(s3_reg.t3) << 1;
        h00w = t3x - t2s - (t2s << 1) + ((HW+2)'(1) << (3 * F));
        h01w = t2s + (t2s << 1) - t3x;
        // both tangents carry half of d21; weigh it by h10 + h11 of the live ones
        he0  = s3_reg.e0 ? s3_reg.h10  : '0;
        he1  = s3_reg.e1 ? s3_reg.h11m : '0;
        s4_next.sd.ys1  = s3_reg.ys1;
        s4_next.sd.ys2  = s3_reg.ys2;
        s4_next.sd.sg0  = s3_reg.sg0;
        s4_next.sd.sg1  = s3_reg.sg1;
        s4_next.sd.e0   = s3_reg.e0;
        s4_next.sd.e1   = s3_reg.e1;
        s4_next.sd.xm10 = s3_reg.xm10;
        s4_next.sd.xm32 = s3_reg.xm32;
        if (he0 >= he1)
        begin
            s4_next.hcm   = he0 - he1;
            s4_next.sd.cs = s3_reg.ds21;
        end
        else
        begin
            s4_next.hcm   = he1 - he0;
            s4_next.sd.cs = !s3_reg.ds21;
        end
        s4_next.ym1  = s3_reg.ym1;
        s4_next.ym2  = s3_reg.ym2;
        s4_next.dm21 = s3_reg.dm21;
        s4_next.h00  = h00w[HW-1:0];
        s4_next.h01  = h01w[HW-1:0];
        s4_next.h10  = s3_reg.h10;
        s4_next.h11m = s3_reg.h11m;
        s4_next.p0m  = s3_reg.p0m;
        s4_next.p1m  = s3_reg.p1m;
    end

    // ---------------- stages 5 and 6: wide products, split into partial products
    logic [HW+W-1:0] pa, pb, pc;
    logic [NW-1:0]   n0, n1;
    side_t           s5_reg, s6_reg;

    hsi_mul #(.AW(HW), .BW(W)) u_mul_a
    (
        .clk (clk),
        .en  (en),
        .a   (s4_reg.h00),
        .b   (s4_reg.ym1),
        .p   (pa)
    );

    hsi_mul #(.AW(HW), .BW(W)) u_mul_b
    (
        .clk (clk),
        .en  (en),
        .a   (s4_reg.h01),
        .b   (s4_reg.ym2),
        .p   (pb)
    );

    hsi_mul #(.AW(HW), .BW(W)) u_mul_c
    (
        .clk (clk),
        .en  (en),
        .a   (s4_reg.hcm),
        .b   (s4_reg.dm21),
        .p   (pc)
    );

    hsi_mul #(.AW(2 * W), .BW(HW)) u_mul_n0
    (
        .clk (clk),
        .en  (en),
        .a   (s4_reg.p0m),
        .b   (s4_reg.h10),
        .p   (n0)
    );

    hsi_mul #(.AW(2 * W), .BW(HW)) u_mul_n1
    (
        .clk (clk),
        .en  (en),
        .a   (s4_reg.p1m),
        .b   (s4_reg.h11m),
        .p   (n1)
    );

    // ---------------- stage 7: integer part from the endpoints, divider operands
    sb_t           sb7_reg, sb7_next;
    logic [NW-1:0] num0_reg, num0_next, num1_reg, num1_next;
    logic [W-1:0]  den0_reg, den0_next, den1_reg, den1_next;

    always_comb
    begin
        logic [IA-1:0] ta, tb, tc;
        ta = s6_reg.ys1 ? (~IA'(pa) + 1'b1) : IA'(pa);
        tb = s6_reg.ys2 ? (~IA'(pb) + 1'b1) : IA'(pb);
        tc = s6_reg.cs  ? (~IA'(pc) + 1'b1) : IA'(pc);
        // twice the endpoint blend plus the half-slope term, all over 2^K
        sb7_next.isum = (ta << 1) + (tb << 1) + tc;
        sb7_next.sg0  = s6_reg.sg0;
        sb7_next.sg1  = s6_reg.sg1;
        // a dead tangent divides zero by one
        num0_next = s6_reg.e0 ? n0 : '0;
        num1_next = s6_reg.e1 ? n1 : '0;
        den0_next = s6_reg.e0 ? s6_reg.xm10 : W'(1);
        den1_next = s6_reg.e1 ? s6_reg.xm32 : W'(1);
    end

    // ---------------- divider stages, sideband follows in a matching delay line
    logic [NW-1:0] q0, q1;
    logic [W-1:0]  r0, r1, a0, a1;
    sb_t           sbd_reg [NW];

    hsi_div #(.NW(NW), .DW(W)) u_div_0
    (
        .clk     (clk),
        .en      (en),
        .num     (num0_reg),
        .den     (den0_reg),
        .quo     (q0),
        .rem     (r0),
        .den_out (a0)
    );

    hsi_div #(.NW(NW), .DW(W)) u_div_1
    (
        .clk     (clk),
        .en      (en),
        .num     (num1_reg),
        .den     (den1_reg),
        .quo     (q1),
        .rem     (r1),
        .den_out (a1)
    );

    // ---------------- D1: signed quotients in floor form, fractional remainders
    d1_t d1_reg, d1_next;

    always_comb
    begin
        logic sg0, sg1, rz0, rz1;
        sg0 = sbd_reg[NW-1].sg0;
        sg1 = sbd_reg[NW-1].sg1;
        rz0 = (r0 == '0);
        rz1 = (r1 == '0);
        d1_next.isum = sbd_reg[NW-1].isum;
        d1_next.a0   = a0;
        d1_next.a1   = a1;
        // a negative quotient with a remainder floors to -(q+1), the fraction flips
        if (sg0)
        begin
            d1_next.i0  = rz0 ? (~TW'(q0) + 1'b1) : ~TW'(q0);
            d1_next.rr0 = rz0 ? '0 : (a0 - r0);
        end
        else
        begin
            d1_next.i0  = TW'(q0);
            d1_next.rr0 = r0;
        end
        if (sg1)
        begin
            d1_next.i1  = rz1 ? (~TW'(q1) + 1'b1) : ~TW'(q1);
            d1_next.rr1 = rz1 ? '0 : (a1 - r1);
        end
        else
        begin
            d1_next.i1  = TW'(q1);
            d1_next.rr1 = r1;
        end
    end

    // ---------------- D2: integer sum, cross products of the two fractions
    d2_t d2_reg, d2_next;

    always_comb
    begin
        d2_next.isum2 = {{(TW-IA){d1_reg.isum[IA-1]}}, d1_reg.isum} + d1_reg.i0 + d1_reg.i1;
        d2_next.f0    = (2*W)'(d1_reg.rr0) * (2*W)'(d1_reg.a1);
        d2_next.f1    = (2*W)'(d1_reg.rr1) * (2*W)'(d1_reg.a0);
        d2_next.aa    = (2*W)'(d1_reg.a0) * (2*W)'(d1_reg.a1);
    end

    // ---------------- D3: does the fraction sum reach one, is it whole
    d3_t d3_reg, d3_next;

    always_comb
    begin
        logic [2*W:0] fs;
        fs = (2*W+1)'(d2_reg.f0) + (2*W+1)'(d2_reg.f1);
        d3_next.isum2 = d2_reg.isum2;
        d3_next.cy    = fs >= (2*W+1)'(d2_reg.aa);
        d3_next.zr    = (fs == '0) || (fs == (2*W+1)'(d2_reg.aa));
    end

    // ---------------- D4: fold the carry into the integer part
    d4_t d4_reg, d4_next;

    always_comb
    begin
        d4_next.ip = d3_reg.isum2 + TW'(d3_reg.cy);
        d4_next.zr = d3_reg.zr;
    end

    // ---------------- D5: round half away from zero on the magnitude
    d5_t d5_reg, d5_next;

    always_comb
    begin
        logic [TW:0] pre;
        logic        neg;
        neg = d4_reg.ip[TW-1];
        // negative with a fraction left: magnitude is ~ip plus the fraction
        pre = (neg ? {1'b0, ~d4_reg.ip} : {1'b0, d4_reg.ip})
            + ((neg && d4_reg.zr) ? (HALF + (TW+1)'(1)) : HALF);
        d5_next.mag = pre[TW:K];
        d5_next.neg = neg;
    end

    // ---------------- D6: clamp to the value range, output register
    logic [W-1:0] value_reg, value_next;
    logic         sat_reg, sat_next;

    always_comb
    begin
        logic [W-1:0] vneg;
        vneg     = ~d5_reg.mag[W-1:0] + 1'b1;
        sat_next = d5_reg.neg ? (d5_reg.mag > MINMAG) : (d5_reg.mag > MAXMAG);
        if (sat_next)
        begin
            value_next = d5_reg.neg ? MIN_V : MAX_V;
        end
        else
        begin
            value_next = d5_reg.neg ? vneg : d5_reg.mag[W-1:0];
        end
    end

    // ---------------- data registers, all advance together on en
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            s4_reg    <= s4_next;
            s5_reg    <= s4_reg.sd;
            s6_reg    <= s5_reg;
            sb7_reg   <= sb7_next;
            num0_reg  <= num0_next;
            num1_reg  <= num1_next;
            den0_reg  <= den0_next;
            den1_reg  <= den1_next;
            sbd_reg[0] <= sb7_reg;
            for (int k = 1; k < NW; k++)
            begin
                sbd_reg[k] <= sbd_reg[k-1];
            end
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            d3_reg    <= d3_next;
            d4_reg    <= d4_next;
            d5_reg    <= d5_next;
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = OUT_TW'(value_reg);
    assign m_tuser  = sat_reg;

    // ---------------- checks
    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[W-1:0] == MAX_V || m_tdata[W-1:0] == MIN_V))
        else $error("saturated result is not clamped to a range limit");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_OUT] |-> ((r0 < a0) && (r1 < a1)))
        else $error("divider remainder not below divisor");

endmodule
